@@ hdl/srg_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the segment ramp generator
// no dependencies; used by the arithmetic units and the top level
package srg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_APPEND  = 2'd2,
    REQ_REPLACE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_LIN  = 2'd1,
    SH_LOG  = 2'd2,
    SH_STEP = 2'd3
  } shape_t;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL = 4'd1;

  localparam logic [15:0] TICK_RATE_RST  = 16'd689;
  localparam logic [31:0] INIT_LEVEL_RST = 32'd0;
  localparam logic [31:0] LOG_FLOOR      = 32'd66;
  localparam logic [31:0] HOLD_LIMIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
  localparam logic [31:0] LEVEL_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] LEVEL_MIN      = 32'h8000_0000;
  localparam logic [46:0] STEP_MAX       = 47'h7FFF_FFFF_FFFF;

  // one queued segment
  typedef struct packed {
    logic signed [31:0] target;
    logic [23:0]        dur;
    logic [1:0]         shape;
  } seg_entry_t;

  // operands of the shared multiplier
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef logic [29:0][31:0] root_tbl_t;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    res = '0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      bitv = 64'd1 << (2 * k);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // successive square roots of 2 in Q.30, entry b used for fraction bit b
  function automatic root_tbl_t root_table();
    root_tbl_t   t;
    logic [63:0] a;
    a = 64'd1 << 31;
    for (int i = 29; i >= 0; i--) begin
      a = isqrt_c(a << 30);
      t[i] = a[31:0];
    end
    return t;
  endfunction

  localparam root_tbl_t ROOT_TBL = root_table();

endpackage

@@ hdl/srg_if.sv @@
`timescale 1ns / 1ps
// channel interfaces of the segment ramp generator: request, response, config write
// no dependencies
interface srg_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] level;
  logic signed [31:0] target;
  logic [23:0]        seg_duration;
  logic [1:0]         seg_shape;
  modport source (output valid, req_type, level, target, seg_duration, seg_shape,
                  input ready);
  modport sink (input valid, req_type, level, target, seg_duration, seg_shape,
                output ready);
endinterface

interface srg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_level;
  logic               changed;
  logic               holding;
  logic               status;
  modport source (output valid, current_level, changed, holding, status, input ready);
  modport sink (input valid, current_level, changed, holding, status, output ready);
endinterface

interface srg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/srg_mul.sv @@
`timescale 1ns / 1ps
// shared 32x32 unsigned multiplier with registered product
// depends on srg_pkg
module srg_mul (
  input  logic             clk,
  input  srg_pkg::mul_req_t req,
  output logic [63:0]      p
);

  always_ff @(posedge clk) begin
    p <= 64'(req.a) * 64'(req.b);
  end

endmodule

@@ hdl/srg_div.sv @@
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 32-bit divisor
// depends on srg_pkg
module srg_div #(
  parameter int DW = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        num,
  input  logic [31:0]          den,
  output logic [DW-1:0]        q,
  output srg_pkg::div_stat_t   st
);

  localparam int CW = $clog2(DW + 1);

  logic [31:0]   rem;
  logic [CW-1:0] cnt;
  logic [32:0]   trial;
  logic [31:0]   den_r;

  assign trial = {rem, q[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st.done <= 1'b0;
      if (start) begin
        st.busy <= 1'b1;
        cnt     <= CW'(DW);
        q       <= num;
        rem     <= '0;
        den_r   <= den;
      end else if (st.busy) begin
        if (trial >= {1'b0, den_r}) begin
          rem <= 32'(trial - {1'b0, den_r});
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          q   <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          st.busy <= 1'b0;
          st.done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/segment_ramp_generator_unit.sv @@
`timescale 1ns / 1ps
// segment ramp generator top level: sequencer, segment queue and state registers
// depends on srg_pkg, srg_if, srg_mul, srg_div
//
// One request transaction is taken at a time and gives exactly one response
// transaction. Work runs through one shared 32x32 multiplier and one radix-2
// divider under a small sequencer. A logarithmic tick walks the fraction bits
// of the exponent for the 2^x chain, with a multiply for each set bit; a
// segment start adds the divider for linear, and for logarithmic a leading one
// search plus 30 squarings per log2, once for the target and once for the
// start level, then the divider. The response waits in an output register, so
// the sink may stall; the next request is taken once the sequencer is back in
// idle. Configuration writes are taken in idle only; writing initial_level also
// reloads the level and empties the queue.
// There is no clearing pass after reset: queue entries are read only once written.
module segment_ramp_generator_unit #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int STEP_FRAC_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  srg_req_if.sink     req,
  srg_rsp_if.source   rsp,
  srg_cfg_if.sink     cfg
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = PTR_W + 2;
  localparam int DIV_W   = STEP_FRAC_BITS + 16;
  localparam int LIN_SH  = STEP_FRAC_BITS - 16;
  localparam int LOG_SHL = (STEP_FRAC_BITS > 30) ? STEP_FRAC_BITS - 30 : 0;
  localparam int LOG_SHR = (STEP_FRAC_BITS < 30) ? 30 - STEP_FRAC_BITS : 0;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_DISP   = 18'b000000000000000010,
    S_TMUL0  = 18'b000000000000000100,
    S_TMUL1  = 18'b000000000000001000,
    S_TMUL2  = 18'b000000000000010000,
    S_EXP    = 18'b000000000000100000,
    S_EXPW   = 18'b000000000001000000,
    S_SCALE  = 18'b000000000010000000,
    S_SCALEW = 18'b000000000100000000,
    S_START  = 18'b000000001000000000,
    S_NMUL   = 18'b000000010000000000,
    S_NW     = 18'b000000100000000000,
    S_NORM   = 18'b000001000000000000,
    S_SQ     = 18'b000010000000000000,
    S_SQW    = 18'b000100000000000000,
    S_DIV    = 18'b001000000000000000,
    S_DIVW   = 18'b010000000000000000,
    S_DONE   = 18'b100000000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0]        tick_rate;
  logic signed [31:0] initial_level;

  // ramp state
  logic signed [31:0] level_reg;
  logic signed [31:0] start_level;
  logic signed [47:0] step_amount;
  logic [31:0]        tick_count;
  logic [31:0]        tick_limit;
  srg_pkg::shape_t    active_shape;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;

  // latched request
  srg_pkg::req_kind_t in_type;
  logic signed [31:0] in_level;
  logic signed [31:0] in_target;
  logic [23:0]        in_dur;
  logic [1:0]         in_shape;
  logic signed [31:0] level_prev;
  logic               stat;

  // sequencer work registers
  logic [63:0]        wk;
  logic [30:0]        m;
  logic [29:0]        frac;
  logic [4:0]         p_exp;
  logic [4:0]         iter;
  logic               log_pass;
  logic signed [35:0] lt;
  logic               neg;
  logic [DIV_W-1:0]   div_num;
  logic [29:0]        e_f;
  logic signed [33:0] e_ip;
  logic [31:0]        r;
  logic [4:0]         ebit;

  // response register
  logic               out_valid;
  logic signed [31:0] out_level;
  logic               out_changed;
  logic               out_holding;
  logic               out_status;

  // segment queue
  srg_pkg::seg_entry_t mem [QUEUE_DEPTH];
  srg_pkg::seg_entry_t mem_q;
  srg_pkg::seg_entry_t mem_wdata;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;

  // shared units
  srg_pkg::mul_req_t   mreq;
  logic [63:0]         p_mul;
  logic                div_start;
  logic [DIV_W-1:0]    div_q;
  srg_pkg::div_stat_t  div_st;

  // combinational helpers
  logic [31:0]        tick_inc;
  logic               q_full;
  logic [PTR_W-1:0]   head_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [47:0]        step_abs;
  logic [79:0]        prod_full;
  logic [62:0]        cap62;
  logic [62:0]        lin_m;
  logic [40:0]        lin_mc;
  logic signed [42:0] lin_sum;
  logic signed [31:0] lin_level;
  logic [48:0]        cap48;
  logic [63:0]        log_m;
  logic [63:0]        log_e;
  logic signed [32:0] seg_d;
  logic [31:0]        seg_dabs;
  logic signed [31:0] log_tgt;
  logic               lvl_nonpos;
  logic [31:0]        sq;
  logic [29:0]        frac_new;
  logic signed [35:0] lg;
  logic signed [36:0] log_d;
  logic [35:0]        log_dabs;
  logic [63:0]        div_q64;
  logic [46:0]        q_sat;
  logic signed [35:0] sh;
  logic [35:0]        nsh;
  logic [63:0]        scale_v;
  logic signed [31:0] exp_level;

  srg_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p   (p_mul)
  );

  srg_div #(.DW(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (tick_limit),
    .q     (div_q),
    .st    (div_st)
  );

  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);

  assign rsp.valid         = out_valid;
  assign rsp.current_level = out_level;
  assign rsp.changed       = out_changed;
  assign rsp.holding       = out_holding;
  assign rsp.status        = out_status;

  assign div_start = (state == S_DIV) && (tick_limit != '0);

  // queue pointers
  always_comb begin
    q_full   = (count >= CNT_W'(QUEUE_DEPTH));
    head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    mem_we = (state == S_DISP) &&
             ((in_type == srg_pkg::REQ_APPEND && !q_full) ||
              in_type == srg_pkg::REQ_REPLACE);
    mem_waddr        = (in_type == srg_pkg::REQ_REPLACE) ? '0 : tail;
    mem_wdata.target = in_target;
    mem_wdata.dur    = in_dur;
    mem_wdata.shape  = in_shape;
  end

  // multiplier operand selection
  always_comb begin
    mreq = '0;
    case (state)
      S_TMUL0:  mreq = '{a: step_abs[31:0], b: tick_count};
      S_TMUL1:  mreq = '{a: {17'b0, step_abs[46:32]}, b: tick_count};
      S_EXP:    mreq = '{a: r, b: srg_pkg::ROOT_TBL[ebit]};
      S_SCALE:  mreq = '{a: start_level, b: r};
      S_NMUL:   mreq = '{a: {8'b0, mem_q.dur}, b: {16'b0, tick_rate}};
      S_SQ:     mreq = '{a: {1'b0, m}, b: {1'b0, m}};
      default:  mreq = '0;
    endcase
  end

  // datapath helpers
  always_comb begin
    tick_inc = tick_count + 32'd1;
    step_abs = step_amount[47] ? 48'(-step_amount) : step_amount;

    // tick product: low partial in wk, high partial on the multiplier output
    prod_full = {16'b0, wk} + ({16'b0, p_mul} << 32);

    // linear tick
    cap62     = (prod_full > (80'd1 << 62)) ? (63'd1 << 62) : prod_full[62:0];
    lin_m     = cap62 >> LIN_SH;
    lin_mc    = (lin_m > (63'd1 << 40)) ? (41'd1 << 40) : lin_m[40:0];
    lin_sum   = step_amount[47] ? (43'(start_level) - $signed({2'b0, lin_mc}))
                                : (43'(start_level) + $signed({2'b0, lin_mc}));
    if (lin_sum > 43'sd2147483647) begin
      lin_level = srg_pkg::LEVEL_MAX;
    end else if (lin_sum < -43'sd2147483648) begin
      lin_level = srg_pkg::LEVEL_MIN;
    end else begin
      lin_level = lin_sum[31:0];
    end

    // logarithmic tick exponent
    cap48 = (prod_full > (80'd1 << 48)) ? (49'd1 << 48) : prod_full[48:0];
    log_m = (64'(cap48) << LOG_SHR) >> LOG_SHL;
    log_e = step_amount[47] ? (64'd0 - log_m) : log_m;

    // segment start
    seg_d      = 33'(mem_q.target) - 33'(start_level);
    seg_dabs   = seg_d[32] ? 32'(-seg_d) : seg_d[31:0];
    log_tgt    = (mem_q.target[31] || mem_q.target == '0) ? srg_pkg::LOG_FLOOR
                                                         : mem_q.target;
    lvl_nonpos = level_reg[31] || (level_reg == '0);

    // log2 squaring step
    sq       = p_mul[61:30];
    frac_new = {frac[28:0], sq[31]};
    lg       = {6'(p_exp) - 6'd16, frac_new};
    log_d    = 37'(lt) - 37'(lg);
    log_dabs = log_d[36] ? 36'(-log_d) : log_d[35:0];

    // divider result, saturated
    div_q64 = 64'(div_q);
    q_sat   = (div_q64 > 64'(srg_pkg::STEP_MAX)) ? srg_pkg::STEP_MAX : div_q64[46:0];

    // final scale of the logarithmic tick
    sh  = 36'sd30 - 36'(e_ip);
    nsh = 36'(-sh);
    if (!sh[35]) begin
      if (sh >= 36'sd63) begin
        scale_v = '0;
      end else begin
        scale_v = p_mul >> sh[5:0];
      end
    end else if (nsh >= 36'd32 || p_mul > (64'h7FFF_FFFF >> nsh[4:0])) begin
      scale_v = 64'(srg_pkg::LEVEL_MAX);
    end else begin
      scale_v = p_mul << nsh[4:0];
    end
    exp_level = (scale_v > 64'h7FFF_FFFF) ? srg_pkg::LEVEL_MAX : scale_v[31:0];
  end

  // segment queue storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[head];
  end

  // response register valid: loaded in done, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_rate     <= srg_pkg::TICK_RATE_RST;
      initial_level <= srg_pkg::INIT_LEVEL_RST;
      level_reg     <= srg_pkg::INIT_LEVEL_RST;
      start_level   <= srg_pkg::INIT_LEVEL_RST;
      step_amount   <= '0;
      tick_count    <= '0;
      tick_limit    <= srg_pkg::HOLD_LIMIT;
      active_shape  <= srg_pkg::SH_HOLD;
      head          <= '0;
      count         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg.valid) begin
            // config transaction; initial_level write is a soft restart
            if (cfg.index == srg_pkg::CFG_TICK_RATE) begin
              tick_rate <= cfg.data[15:0];
            end else if (cfg.index == srg_pkg::CFG_INIT_LEVEL) begin
              initial_level <= cfg.data;
              level_reg     <= cfg.data;
              start_level   <= cfg.data;
              step_amount   <= '0;
              tick_count    <= '0;
              tick_limit    <= srg_pkg::HOLD_LIMIT;
              active_shape  <= srg_pkg::SH_HOLD;
              head          <= '0;
              count         <= '0;
            end
          end else if (req.valid) begin
            in_type    <= srg_pkg::req_kind_t'(req.req_type);
            in_level   <= req.level;
            in_target  <= req.target;
            in_dur     <= req.seg_duration;
            in_shape   <= req.seg_shape;
            level_prev <= level_reg;
            stat       <= 1'b0;
            state      <= S_DISP;
          end
        end

        S_DISP: begin
          case (in_type)
            srg_pkg::REQ_TICK: begin
              if (active_shape == srg_pkg::SH_HOLD) begin
                state <= S_DONE;
              end else begin
                tick_count <= tick_inc;
                if (tick_inc >= tick_limit) begin
                  // segment end: snap to target and pop
                  if (count != '0) begin
                    level_reg <= mem_q.target;
                    head      <= head_inc;
                    count     <= count - CNT_W'(1);
                  end
                  state <= S_START;
                end else if (active_shape == srg_pkg::SH_LIN ||
                             active_shape == srg_pkg::SH_LOG) begin
                  state <= S_TMUL0;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            srg_pkg::REQ_SET: begin
              level_reg <= in_level;
              head      <= '0;
              count     <= '0;
              state     <= S_START;
            end
            srg_pkg::REQ_APPEND: begin
              if (q_full) begin
                stat  <= 1'b1;
                state <= S_DONE;
              end else begin
                count <= count + CNT_W'(1);
                state <= (active_shape == srg_pkg::SH_HOLD) ? S_START : S_DONE;
              end
            end
            srg_pkg::REQ_REPLACE: begin
              level_reg <= in_level;
              head      <= '0;
              count     <= CNT_W'(1);
              state     <= S_START;
            end
            default: state <= S_DONE;
          endcase
        end

        S_TMUL0: state <= S_TMUL1;

        S_TMUL1: begin
          wk    <= p_mul;
          state <= S_TMUL2;
        end

        S_TMUL2: begin
          if (active_shape == srg_pkg::SH_LIN) begin
            level_reg <= lin_level;
            state     <= S_DONE;
          end else begin
            e_f   <= log_e[29:0];
            e_ip  <= log_e[63:30];
            r     <= srg_pkg::ONE_Q30;
            ebit  <= 5'd29;
            state <= S_EXP;
          end
        end

        S_EXP: begin
          // zero fraction bits are skipped without a multiply
          if (e_f[ebit]) begin
            state <= S_EXPW;
          end else if (ebit == 5'd0) begin
            state <= S_SCALE;
          end else begin
            ebit <= ebit - 5'd1;
          end
        end

        S_EXPW: begin
          r <= p_mul[61:30];
          if (ebit == 5'd0) begin
            state <= S_SCALE;
          end else begin
            ebit  <= ebit - 5'd1;
            state <= S_EXP;
          end
        end

        S_SCALE: state <= S_SCALEW;

        S_SCALEW: begin
          level_reg <= exp_level;
          state     <= S_DONE;
        end

        S_START: begin
          tick_count  <= '0;
          start_level <= level_reg;
          if (count == '0) begin
            step_amount  <= '0;
            active_shape <= srg_pkg::SH_HOLD;
            tick_limit   <= srg_pkg::HOLD_LIMIT;
            state        <= S_DONE;
          end else begin
            state <= S_NMUL;
          end
        end

        S_NMUL: state <= S_NW;

        S_NW: begin
          tick_limit   <= p_mul[41:10];
          active_shape <= srg_pkg::shape_t'(mem_q.shape);
          step_amount  <= '0;
          case (srg_pkg::shape_t'(mem_q.shape))
            srg_pkg::SH_LIN: begin
              neg     <= seg_d[32];
              div_num <= DIV_W'(64'(seg_dabs) << LIN_SH);
              state   <= S_DIV;
            end
            srg_pkg::SH_LOG: begin
              if (lvl_nonpos) begin
                level_reg   <= srg_pkg::LOG_FLOOR;
                start_level <= srg_pkg::LOG_FLOOR;
              end
              m        <= log_tgt[30:0];
              p_exp    <= 5'd30;
              frac     <= '0;
              iter     <= '0;
              log_pass <= 1'b0;
              state    <= S_NORM;
            end
            default: state <= S_DONE;
          endcase
        end

        S_NORM: begin
          // leading one search, one bit a cycle
          if (m[30]) begin
            state <= S_SQ;
          end else begin
            m     <= {m[29:0], 1'b0};
            p_exp <= p_exp - 5'd1;
          end
        end

        S_SQ: state <= S_SQW;

        S_SQW: begin
          if ((iter == 5'd29) && !log_pass) begin
            // target done, now the start level
            lt       <= lg;
            log_pass <= 1'b1;
            m        <= start_level[30:0];
            p_exp    <= 5'd30;
            frac     <= '0;
            iter     <= '0;
            state    <= S_NORM;
          end else begin
            m    <= sq[31] ? sq[31:1] : sq[30:0];
            frac <= frac_new;
            iter <= iter + 5'd1;
            if (iter == 5'd29) begin
              neg     <= log_d[36];
              div_num <= DIV_W'((64'(log_dabs) << LOG_SHL) >> LOG_SHR);
              state   <= S_DIV;
            end else begin
              state <= S_SQ;
            end
          end
        end

        S_DIV: begin
          // zero tick limit keeps a zero step
          state <= (tick_limit == '0) ? S_DONE : S_DIVW;
        end

        S_DIVW: begin
          if (div_st.done) begin
            step_amount <= neg ? 48'(-$signed({1'b0, q_sat})) : {1'b0, q_sat};
            state       <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_level   <= level_reg;
            out_changed <= (in_type == srg_pkg::REQ_TICK) && (level_reg != level_prev);
            out_holding <= (active_shape == srg_pkg::SH_HOLD);
            out_status  <= stat;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("segment queue count above depth");

  // a ramp in idle always has its segment in the queue
  a_active_has_seg: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (active_shape != srg_pkg::SH_HOLD) |-> count != '0)
    else $error("active ramp with empty queue");

  // request transaction always leads to dispatch
  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_DISP)
    else $error("accepted request not dispatched");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIVW)
    else $error("divider result without waiting sequencer");

  // step is saturated symmetric
  a_step_sat: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> step_amount != 48'sh8000_0000_0000)
    else $error("step amount out of saturated range");

endmodule
